@@ rtl/core/rosenbrock_fitness_accumulator_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Rosenbrock fitness accumulator
// Shared property templates for the checker.
// ---------------------------------------------------------------------------
`ifndef ROSENBROCK_FITNESS_ACCUMULATOR_CORE_DEFINES_SVH
`define ROSENBROCK_FITNESS_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication
`define RFA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfa check failed");

// next-cycle implication
`define RFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfa check failed");

`endif

@@ rtl/core/rfa_pkg.sv @@
// ---------------------------------------------------------------------------
// rfa_pkg
// Types and fixed constants shared by the accumulator modules.
// ---------------------------------------------------------------------------
package rfa_pkg;

   localparam int ELEM_W = 24;   // element width, signed
   localparam int SUM_W  = 63;   // sum / threshold / fitness width
   localparam int GAIN   = 100;  // Rosenbrock weight on the squared difference
   localparam int GAIN_W = 7;    // bits of GAIN

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // controller -> datapath
   typedef struct packed {
      logic ready;      // item port open
      logic load_item;  // item taken this cycle
      logic square;     // z*z and a*a
      logic diff;       // difference magnitude
      logic mul_lo;     // partial product lo*lo
      logic mul_mid;    // partial product hi*lo
      logic mul_hi;     // partial product hi*hi
      logic scale;      // weight by GAIN, saturate
      logic term;       // pair term
      logic acc;        // running sum
      logic link;       // current element becomes previous
      logic finish;     // emit result, close vector
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic have_prev;
      logic item_last;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/rfa_channels.sv @@
// ---------------------------------------------------------------------------
// Accumulator channel interfaces
// Valid/ready channels for items, results and the threshold register.
// ---------------------------------------------------------------------------
interface rfa_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [rfa_pkg::ELEM_W-1:0]        element;
   logic                                     last;

   modport source (output valid, element, last, input ready);
   modport sink   (input valid, element, last, output ready);
endinterface

interface rfa_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [rfa_pkg::SUM_W-1:0]                fitness;
   logic                                     below_threshold;
   logic                                     converged;

   modport source (output valid, fitness, below_threshold, converged, input ready);
   modport sink   (input valid, fitness, below_threshold, converged, output ready);
endinterface

interface rfa_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [rfa_pkg::SUM_W-1:0]                data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/rfa_ctrl.sv @@
// ---------------------------------------------------------------------------
// rfa_ctrl
// Sequencer: steps an item that closes a pair through square, difference, three
// partial products, scaling and accumulation; every item ends in link or finish.
// ---------------------------------------------------------------------------
module rfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   input  rfa_pkg::status_type  status,
   output rfa_pkg::cmd_type     cmd
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_SQUARE = 11'b00000000010,
      S_DIFF   = 11'b00000000100,
      S_MUL_LO = 11'b00000001000,
      S_MUL_MD = 11'b00000010000,
      S_MUL_HI = 11'b00000100000,
      S_SCALE  = 11'b00001000000,
      S_TERM   = 11'b00010000000,
      S_ACC    = 11'b00100000000,
      S_LINK   = 11'b01000000000,
      S_FINISH = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) begin
               if (status.have_prev) begin
                  state_in = S_SQUARE;
               end else if (req_last) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_LINK;
               end
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_MD;
         end
         S_MUL_MD: begin
            cmd.mul_mid = 1'b1;
            state_in    = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_TERM;
         end
         S_TERM: begin
            cmd.term = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.item_last ? S_FINISH : S_LINK;
         end
         S_LINK: begin
            cmd.link = 1'b1;
            state_in = S_IDLE;
         end
         S_FINISH: begin
            // hold until the result register can take the new result
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/rfa_datapath.sv @@
// ---------------------------------------------------------------------------
// rfa_datapath
// Pair term arithmetic, saturating running sum, threshold and result register.
// ---------------------------------------------------------------------------
module rfa_datapath #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rfa_pkg::cmd_type                    cmd,
   output rfa_pkg::status_type                 status,
   input  logic signed [rfa_pkg::ELEM_W-1:0]   req_element,
   input  logic                                req_last,
   input  logic                                csr_write,
   input  logic [rfa_pkg::SUM_W-1:0]           csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [rfa_pkg::SUM_W-1:0]           rsp_fitness,
   output logic                                rsp_below_threshold,
   output logic                                rsp_converged
);

   localparam int ELEM_W = rfa_pkg::ELEM_W;
   localparam int SUM_W  = rfa_pkg::SUM_W;
   // element + 1.0 needs room for both the element range and the unit
   localparam int Z_W    = ((ELEM_W > FRACTION_BITS + 1) ? ELEM_W : FRACTION_BITS + 1) + 1;
   localparam int SQ_W   = 2 * Z_W;
   localparam int RAW_W  = SQ_W + 1;
   localparam int MAG_W  = RAW_W - FRACTION_BITS;
   localparam int K      = (MAG_W + 1) / 2;          // low half width
   localparam int PROD_W = 2 * MAG_W;
   localparam int P_W    = PROD_W - FRACTION_BITS + rfa_pkg::GAIN_W;
   localparam int WIDE   = (P_W > SUM_W + 1) ? P_W : SUM_W + 1;

   localparam logic signed [Z_W-1:0] ONE_Z = Z_W'(1) << FRACTION_BITS;

   // vector state
   logic signed [Z_W-1:0]  cur_z_ff, cur_z_in;
   logic                   cur_last_ff, cur_last_in;
   logic signed [Z_W-1:0]  prev_z_ff, prev_z_in;
   logic                   have_prev_ff, have_prev_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   sticky_ff, sticky_in;
   logic [SUM_W-1:0]       threshold_ff, threshold_in;

   // work registers
   logic signed [SQ_W-1:0] zz_ff, zz_in;
   logic [SUM_W-1:0]       q_ff, q_in;
   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SUM_W-1:0]       p_ff, p_in;
   logic [SUM_W-1:0]       term_ff, term_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]       fitness_ff, fitness_in;
   logic                   below_ff, below_in;
   logic                   conv_ff, conv_in;

   // combinational helpers
   logic signed [Z_W-1:0]   a_z;
   logic signed [SQ_W-1:0]  pz_ext, a_ext, aa;
   logic signed [RAW_W-1:0] raw, d, neg_d;
   logic [K-1:0]            lo, hi, op_a, op_b;
   logic [2*K-1:0]          pp;
   logic [PROD_W-1:0]       pp_w, addend;
   logic [WIDE-1:0]         p_full;
   logic [SUM_W:0]          term_sum, acc_sum;
   logic                    below;

   always_comb begin
      // z*z and (z - 1.0)^2 of the previous element
      pz_ext = SQ_W'(prev_z_ff);
      zz_in  = pz_ext * pz_ext;
      a_z    = prev_z_ff - ONE_Z;
      a_ext  = SQ_W'(a_z);
      aa     = a_ext * a_ext;
      q_in   = SUM_W'(aa >>> FRACTION_BITS);

      // floor((z^2 - y) >> F), magnitude
      raw    = RAW_W'(zz_ff) - (RAW_W'(cur_z_ff) <<< FRACTION_BITS);
      d      = raw >>> FRACTION_BITS;
      neg_d  = -d;
      mag_in = d[RAW_W-1] ? neg_d[MAG_W-1:0] : d[MAG_W-1:0];

      // one shared half-width multiplier, three passes
      lo     = mag_ff[K-1:0];
      hi     = K'(mag_ff[MAG_W-1:K]);
      op_a   = (cmd.mul_mid || cmd.mul_hi) ? hi : lo;
      op_b   = cmd.mul_hi ? hi : lo;
      pp     = (2*K)'(op_a) * (2*K)'(op_b);
      pp_w   = PROD_W'(pp);
      addend = cmd.mul_hi ? (pp_w << (2 * K)) : (pp_w << (K + 1));
      prod_in = cmd.mul_lo ? pp_w : (prod_ff + addend);

      // 100 * floor(d^2 >> F), saturated
      p_full = WIDE'(prod_ff >> FRACTION_BITS) * WIDE'(rfa_pkg::GAIN);
      p_in   = (|p_full[WIDE-1:SUM_W]) ? rfa_pkg::SUM_MAX : p_full[SUM_W-1:0];

      term_sum = {1'b0, p_ff} + {1'b0, q_ff};
      term_in  = term_sum[SUM_W] ? rfa_pkg::SUM_MAX : term_sum[SUM_W-1:0];

      acc_sum  = {1'b0, sum_ff} + {1'b0, term_ff};

      below    = sum_ff < threshold_ff;

      // state updates
      cur_z_in     = cmd.load_item ? (Z_W'(req_element) + ONE_Z) : cur_z_ff;
      cur_last_in  = cmd.load_item ? req_last : cur_last_ff;
      prev_z_in    = cmd.link ? cur_z_ff : prev_z_ff;
      threshold_in = csr_write ? csr_data : threshold_ff;

      priority if (cmd.link) begin
         have_prev_in = 1'b1;
      end else if (cmd.finish) begin
         have_prev_in = 1'b0;
      end else begin
         have_prev_in = have_prev_ff;
      end

      priority if (cmd.acc) begin
         sum_in = acc_sum[SUM_W] ? rfa_pkg::SUM_MAX : acc_sum[SUM_W-1:0];
      end else if (cmd.finish) begin
         sum_in = '0;
      end else begin
         sum_in = sum_ff;
      end

      sticky_in  = sticky_ff | (cmd.finish & below);

      fitness_in = below ? '0 : sum_ff;
      below_in   = below;
      conv_in    = sticky_ff | below;

      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         sum_ff       <= '0;
         sticky_ff    <= 1'b0;
         threshold_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
         sum_ff       <= sum_in;
         sticky_ff    <= sticky_in;
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_z_ff    <= cur_z_in;
      cur_last_ff <= cur_last_in;
      prev_z_ff   <= prev_z_in;
      if (cmd.square) begin
         zz_ff <= zz_in;
         q_ff  <= q_in;
      end
      if (cmd.diff) begin
         mag_ff <= mag_in;
      end
      if (cmd.mul_lo || cmd.mul_mid || cmd.mul_hi) begin
         prod_ff <= prod_in;
      end
      if (cmd.scale) begin
         p_ff <= p_in;
      end
      if (cmd.term) begin
         term_ff <= term_in;
      end
      if (cmd.finish) begin
         fitness_ff <= fitness_in;
         below_ff   <= below_in;
         conv_ff    <= conv_in;
      end
   end

   assign status.have_prev = have_prev_ff;
   assign status.item_last = cur_last_ff;
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fitness         = fitness_ff;
   assign rsp_below_threshold = below_ff;
   assign rsp_converged       = conv_ff;

endmodule

@@ rtl/core/rosenbrock_fitness_accumulator_core.sv @@
// ---------------------------------------------------------------------------
// Rosenbrock fitness accumulator core
// Scores a candidate vector streamed one coordinate per item.
// ---------------------------------------------------------------------------
// Send the coordinates of a vector as items on req_bus (signed, FRACTION_BITS
// fraction bits) and mark the final one with last. For every adjacent pair
// (a, b) the core adds 100*((a+1)^2-(b+1))^2 + a^2 into an unsigned 63-bit
// sum that saturates at its maximum. The last item yields exactly one result
// on rsp_bus: the sum, or zero with below_threshold set when the sum is under
// the threshold register; converged stays set from then on until reset. A
// one-coordinate vector scores zero. The threshold is written over csr_bus,
// which is always ready; write it only while the core is idle. An item that
// closes no pair goes straight to link or finish; an item that closes a pair
// is walked by the sequencer through square, difference, three passes
// through one shared half-width multiplier, scaling and accumulation. A
// finished result sits in an output register, so the next vector can start
// while it waits; only a second result waits on rsp_ready.
// ---------------------------------------------------------------------------
module rosenbrock_fitness_accumulator_core #(
   parameter int FRACTION_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   rfa_req_if.sink    req_bus,
   rfa_rsp_if.source  rsp_bus,
   rfa_csr_if.sink    csr_bus
);

   rfa_pkg::cmd_type    cmd;
   rfa_pkg::status_type status;

   // threshold register is written on any valid cycle
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = cmd.ready;

   rfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last),
      .status    (status),
      .cmd       (cmd)
   );

   rfa_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_element         (req_bus.element),
      .req_last            (req_bus.last),
      .csr_write           (csr_bus.valid),
      .csr_data            (csr_bus.data),
      .rsp_ready           (rsp_bus.ready),
      .rsp_valid           (rsp_bus.valid),
      .rsp_fitness         (rsp_bus.fitness),
      .rsp_below_threshold (rsp_bus.below_threshold),
      .rsp_converged       (rsp_bus.converged)
   );

endmodule

@@ rtl/core/rfa_checker.sv @@
// ---------------------------------------------------------------------------
// rfa_checker
// Port-level checks on the result channel, bound to the core.
// ---------------------------------------------------------------------------
`include "rosenbrock_fitness_accumulator_core_defines.svh"

module rfa_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [rfa_pkg::SUM_W-1:0]   rsp_fitness,
   input  logic                        rsp_below_threshold,
   input  logic                        rsp_converged
);

   logic [rfa_pkg::SUM_W+1:0] rsp_payload;
   logic                      below_ok;

   assign rsp_payload = {rsp_fitness, rsp_below_threshold, rsp_converged};
   assign below_ok    = (rsp_fitness == '0) && rsp_converged;

   // a stalled result stays offered
   `RFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled result keeps its value
   `RFA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))

   // below threshold forces zero fitness and sets converged
   `RFA_ASSERT_IMPLY(a_below_zero, clock, reset, rsp_valid && rsp_below_threshold, below_ok)

   // nothing offered right after reset
   `RFA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind rosenbrock_fitness_accumulator_core rfa_checker u_rfa_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_fitness         (rsp_bus.fitness),
   .rsp_below_threshold (rsp_bus.below_threshold),
   .rsp_converged       (rsp_bus.converged)
);

@@ test/rosenbrock_fitness_accumulator_core_test.sv @@
// ---------------------------------------------------------------------------
// Rosenbrock fitness accumulator core testbench
// Streams candidate vectors through the core under several threshold
// settings, predicts each fitness result and checks every returned item.
// ---------------------------------------------------------------------------
module rosenbrock_fitness_accumulator_core_test;

   localparam int FRAC    = 16;   // fraction bits of elements and sums
   localparam int SETTLE  = 32;   // idle cycles before a threshold write
   localparam int PHASE_N = 240;  // random items per threshold setting

   typedef logic signed [rfa_pkg::ELEM_W-1:0] elem_t;

   localparam elem_t EL_MAX = {1'b0, {(rfa_pkg::ELEM_W-1){1'b1}}};
   localparam elem_t EL_MIN = {1'b1, {(rfa_pkg::ELEM_W-1){1'b0}}};
   localparam elem_t EL_ONE = elem_t'(1 << FRAC);

   // widest sum the core can hold, kept in 64 bits for the arithmetic below
   localparam logic [63:0] SUM_CAP = {1'b0, rfa_pkg::SUM_MAX};

   typedef struct packed {
      logic [rfa_pkg::SUM_W-1:0] fitness;
      logic                      below;
      logic                      conv;
   } score_t;

   // -----------------------------------------------------------------------
   // Fitness predictor and result store
   // -----------------------------------------------------------------------
   class fitness_scoreboard;
      longint      prev_z;      // previous element plus one
      bit          have_prev;
      logic [63:0] run_sum;     // never above SUM_CAP
      bit          converged;
      logic [63:0] threshold;
      score_t      scores [$];
      int          errors;

      function new();
         prev_z    = 0;
         have_prev = 0;
         run_sum   = 0;
         converged = 0;
         threshold = 0;
         errors    = 0;
      endfunction

      function void set_threshold(logic [rfa_pkg::SUM_W-1:0] v);
         threshold = {1'b0, v};
      endfunction

      function logic [63:0] sat_sum(logic [63:0] x, logic [63:0] y);
         logic [63:0] t;
         t = x + y;   // both operands at most SUM_CAP, so no wrap in 64 bits
         return (t > SUM_CAP) ? SUM_CAP : t;
      endfunction

      // 100*((a+1)^2-(b+1))^2 + a^2 for z = a+1, y = b+1
      function logic [63:0] pair_cost(longint z, longint y);
         longint       one, raw, d, mag, a;
         logic [127:0] wide;
         logic [63:0]  s, p, q;
         one  = longint'(1) <<< FRAC;
         raw  = z * z - y * one;
         d    = raw >>> FRAC;                // floor toward minus infinity
         mag  = (d < 0) ? -d : d;
         wide = (128'(mag) * 128'(mag)) >> FRAC;
         s    = (wide > 128'(SUM_CAP)) ? SUM_CAP : wide[63:0];
         p    = (s > SUM_CAP / rfa_pkg::GAIN) ? SUM_CAP : s * rfa_pkg::GAIN;
         a    = z - one;
         q    = a * a;
         q    = q >> FRAC;
         return sat_sum(p, q);
      endfunction

      function void note_item(elem_t e, logic last);
         longint z;
         score_t r;
         z = longint'(e) + (longint'(1) <<< FRAC);
         if (have_prev)
            run_sum = sat_sum(run_sum, pair_cost(prev_z, z));
         if (!last) begin
            prev_z    = z;
            have_prev = 1;
            return;
         end
         r.below = (run_sum < threshold);
         if (r.below)
            converged = 1;
         r.fitness = r.below ? '0 : run_sum[rfa_pkg::SUM_W-1:0];
         r.conv    = converged;
         scores.push_back(r);
         run_sum   = 0;
         have_prev = 0;
         prev_z    = 0;
      endfunction

      function void check_result(logic [rfa_pkg::SUM_W-1:0] f, logic b, logic c);
         score_t x;
         if (scores.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: fitness=%0d below=%0b converged=%0b",
                     $time, f, b, c);
            return;
         end
         x = scores.pop_front();
         if (x.fitness !== f || x.below !== b || x.conv !== c) begin
            errors++;
            $display("%0t: result mismatch: expected fitness=%0d below=%0b converged=%0b,",
                     $time, x.fitness, x.below, x.conv,
                     " got fitness=%0d below=%0b converged=%0b", f, b, c);
         end
      endfunction

      function int pending();
         return scores.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bit steady;             // phase without idle gaps on either side
   bit hold_off_request;   // ask the result side for one long stall

   fitness_scoreboard sb;

   rfa_req_if req_bus ();
   rfa_rsp_if rsp_bus ();
   rfa_csr_if csr_bus ();

   rosenbrock_fitness_accumulator_core #(
      .FRACTION_BITS(FRAC)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -----------------------------------------------------------------------
   // Random shaping helpers
   // -----------------------------------------------------------------------

   // sender gap: mostly back to back or short, now and then a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady)  return 0;
      if (r < 55)  return 0;
      if (r < 85)  return $urandom_range(1, 3);
      if (r < 97)  return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // vector length: mostly short, a few long ones to pile up the sum
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 6);
      if (r < 95) return $urandom_range(7, 20);
      return $urandom_range(21, 64);
   endfunction

   // element by flavor: full range, near +-2.0, the corner values, near zero
   function automatic elem_t pick_element(int mode);
      int v;
      case (mode)
         0: begin
            return elem_t'($urandom);
         end
         1: begin
            v = int'($urandom_range(0, 262144)) - 131072;
            return elem_t'(v);
         end
         2: begin
            case ($urandom_range(0, 5))
               0: return EL_MAX;
               1: return EL_MIN;
               2: return EL_ONE;
               3: return -EL_ONE;
               4: return elem_t'(-1);
               default: return '0;
            endcase
         end
         default: begin
            v = int'($urandom_range(0, 512)) - 256;
            return elem_t'(v);
         end
      endcase
   endfunction

   // threshold spread over many orders of magnitude
   function automatic logic [rfa_pkg::SUM_W-1:0] wide_threshold();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return rfa_pkg::SUM_W'(r >> $urandom_range(1, 63));
   endfunction

   // -----------------------------------------------------------------------
   // Drivers
   // -----------------------------------------------------------------------

   // threshold write; caller makes sure the core is idle
   task automatic write_threshold(logic [rfa_pkg::SUM_W-1:0] thr);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= thr;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_threshold(thr);
      csr_bus.valid <= 1'b0;
   endtask

   // one element; valid stays up when the next item follows with no gap
   task automatic send_item(elem_t e, logic last, int gap);
      req_bus.valid   <= 1'b1;
      req_bus.element <= e;
      req_bus.last    <= last;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_item(e, last);
      if (gap > 0) begin
         req_bus.valid   <= 1'b0;
         req_bus.element <= elem_t'($urandom);
         req_bus.last    <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every outstanding result, then let the pipeline go quiet
   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // corner cases first, all under a zero threshold
   task automatic run_directed();
      elem_t pts [23] = '{
         EL_MAX,                         // lone element, no pair
         EL_MIN,                         // lone element at the other end
         '0, '0,                         // (a+1)^2 == b+1, term is zero
         EL_MAX, EL_MIN,                 // largest square, smallest b
         EL_MIN, EL_MAX,
         EL_MIN, EL_MIN, EL_MAX, EL_MAX,
         -EL_ONE, '0,                    // a = -1: negative difference
         -EL_ONE + elem_t'(1), elem_t'(5), EL_ONE, elem_t'(-1), // inexact negative
         EL_ONE, EL_ONE,
         elem_t'(-1), elem_t'(1), elem_t'(24'h7F0000)
      };
      bit ends [23] = '{1, 1, 0, 1, 0, 1, 0, 1, 0, 0, 0, 1, 0, 1,
                        0, 0, 0, 1, 0, 1, 0, 0, 1};
      int gap;
      write_threshold('0);
      steady = 0;
      for (int i = 0; i < 23; i++) begin
         gap = pick_gap();
         if (i == 22 && gap == 0)
            gap = 1;
         send_item(pts[i], ends[i], gap);
      end
      drain();
   endtask

   // one threshold setting, whole vectors only, then a full drain
   task automatic run_phase(logic [rfa_pkg::SUM_W-1:0] thr, bit calm, bit squeeze);
      int    sent, len, mode, gap;
      elem_t e;
      write_threshold(thr);
      steady = calm;
      if (squeeze)
         hold_off_request = 1;
      sent = 0;
      while (sent < PHASE_N) begin
         len  = pick_len();
         mode = $urandom_range(0, 3);
         for (int k = 0; k < len; k++) begin
            // mostly the vector's own flavor, some mixed in from the others
            e   = pick_element(($urandom_range(0, 99) < 85) ? mode : $urandom_range(0, 3));
            gap = pick_gap();
            if (k == len - 1 && sent + len >= PHASE_N && gap == 0)
               gap = 1;
            send_item(e, k == len - 1, gap);
         end
         sent += len;
      end
      drain();
   endtask

   // -----------------------------------------------------------------------
   // Result side: ready pattern and checking
   // -----------------------------------------------------------------------
   initial begin
      int hold;
      hold          = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_result(rsp_bus.fitness, rsp_bus.below_threshold, rsp_bus.converged);
         if (hold_off_request) begin
            // long stall: the output register fills and the core stops taking items
            hold_off_request = 0;
            hold             = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (steady || $urandom_range(0, 9) < 7) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            hold = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                             : $urandom_range(10, 40);
         end
      end
   end

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      sb               = new();
      steady           = 0;
      hold_off_request = 0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.element  = '0;
      req_bus.last     = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.data     = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // threshold zero: nothing can fall below, converged stays clear
      run_phase('0, 1, 0);
      // spread threshold while the result side stalls for a long stretch
      run_phase(wide_threshold(), 0, 1);
      // threshold in the range of sums from small elements: mixed outcomes
      run_phase(rfa_pkg::SUM_W'($urandom_range(0, 32'h7FFF_FFFF)), 0, 0);
      run_phase(wide_threshold(), 0, 0);
      // threshold one: lone elements and zero sums fall below
      run_phase(rfa_pkg::SUM_W'(1), 0, 0);
      // threshold at its top: every sum short of saturation falls below
      run_phase(rfa_pkg::SUM_MAX, 0, 0);
      // back to zero, converged must stay set
      run_phase('0, 0, 0);
      run_phase(wide_threshold(), 1, 0);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
